/* rtl/tccs_pkg.sv */
`timescale 1ns / 1ps

package tccs_pkg;

	// Screen geometry
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	// Field widths fixed by the interface
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int CELL_W = 16;
	localparam int ADDR_W = $clog2(CELLS);

	localparam logic [ROW_W-1:0] ROW_LIMIT = ROW_W'(ROWS);
	localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(COLUMNS);

	localparam logic [7:0] ATTR_RESET   = 8'h0f;
	localparam logic [7:0] NEWLINE_CODE = 8'd10;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		OP_PUT_CHAR,
		OP_NEWLINE,
		OP_READ,
		OP_READ_ZERO
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [7:0]       code;
		logic [ROW_W-1:0] row;
		logic [COL_W-1:0] col;
	} cmd_t;

endpackage

/* rtl/tccs_front.sv */
`timescale 1ns / 1ps

module tccs_front import tccs_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic             kind,
	input  logic [7:0]       char_code,
	input  logic [ROW_W-1:0] read_row,
	input  logic [COL_W-1:0] read_col,
	input  logic             busy,
	output logic             cmd_valid,
	output cmd_t             cmd,
	input  logic             cmd_pop
);

	cmd_t              q_mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	cmd_t              cls;
	logic              push;

	// Classify the incoming item
	always_comb begin
		cls.code = char_code;
		cls.row  = read_row;
		cls.col  = read_col;
		if (kind) begin
			if (read_row < ROW_LIMIT && read_col < COL_LIMIT)
				cls.op = OP_READ;
			else
				cls.op = OP_READ_ZERO;
		end else if (char_code == NEWLINE_CODE) begin
			cls.op = OP_NEWLINE;
		end else begin
			cls.op = OP_PUT_CHAR;
		end
	end

	// Hold off transfers while full or while the store is being cleared
	assign in_stall  = busy || (count_q == QCNT_W'(QUEUE_DEPTH));
	assign push      = in_valid && !in_stall;
	assign cmd_valid = (count_q != '0);
	assign cmd       = q_mem_q[rd_ptr_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push)
			q_mem_q[wr_ptr_q] <= cls;
	end

	// Queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (cmd_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !cmd_pop)
				count_q <= count_q + 1'b1;
			else if (!push && cmd_pop)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

/* rtl/tccs_back.sv */
`timescale 1ns / 1ps

module tccs_back import tccs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata,
	input  logic              cmd_valid,
	input  cmd_t              cmd,
	output logic              cmd_pop,
	output logic              busy,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CELL_W-1:0] cell_value,
	output logic [COL_W-1:0]  cursor_col,
	output logic [ROW_W-1:0]  cursor_row
);

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_SCROLL = 5'b00100,
		ST_PUT    = 5'b01000,
		ST_READ   = 5'b10000
	} state_t;

	state_t             state_q;
	logic [CELL_W-1:0]  mem_q [CELLS];
	logic [CELL_W-1:0]  rd_data_q;
	logic [7:0]         attr_q;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [ROW_W-1:0]   top_q;
	logic [ADDR_W-1:0]  clr_addr_q;
	logic [ADDR_W-1:0]  clr_end_q;
	cmd_t               cmd_q;
	logic               rd_zero_q;
	logic               out_valid_q;
	logic [CELL_W-1:0]  cell_q;
	logic [COL_W-1:0]   ocol_q;
	logic [ROW_W-1:0]   orow_q;

	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [CELL_W-1:0]  mem_wdata;
	logic               mem_re;
	logic [ADDR_W-1:0]  mem_raddr;
	logic               out_free;
	logic               out_load;
	logic               wrap;
	logic [COL_W-1:0]   col_w;
	logic [ROW_W-1:0]   row_w;
	logic               scroll;
	logic [ROW_W-1:0]   top_next;

	// Logical row to store address; rows rotate by the top pointer
	function automatic logic [ADDR_W-1:0] phys_addr(input logic [ROW_W-1:0] r,
	                                                input logic [COL_W-1:0] c,
	                                                input logic [ROW_W-1:0] t);
		logic [ROW_W:0] s;
		s = {1'b0, r} + {1'b0, t};
		if (s >= (ROW_W+1)'(ROWS))
			s = s - (ROW_W+1)'(ROWS);
		return ADDR_W'(s * COLUMNS) + ADDR_W'(c);
	endfunction

	assign busy       = (state_q == ST_CLEAR);
	assign out_free   = !out_valid_q || !out_stall;
	assign out_load   = out_free && (state_q == ST_PUT || state_q == ST_READ);
	assign out_valid  = out_valid_q;
	assign cell_value = cell_q;
	assign cursor_col = ocol_q;
	assign cursor_row = orow_q;

	// Pending wrap and scroll
	assign wrap     = (col_q >= COL_LIMIT);
	assign col_w    = wrap ? '0 : col_q;
	assign row_w    = wrap ? row_q + 1'b1 : row_q;
	assign scroll   = (row_w >= ROW_LIMIT);
	assign top_next = (top_q == ROW_LIMIT - 1'b1) ? '0 : top_q + 1'b1;

	// Store port control
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_addr_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = phys_addr(cmd.row, cmd.col, top_q);
		cmd_pop   = 1'b0;
		unique case (state_q)
			ST_CLEAR, ST_SCROLL: begin
				mem_we = 1'b1;
			end
			ST_IDLE: begin
				cmd_pop = cmd_valid;
				mem_re  = cmd_valid && (cmd.op == OP_READ);
			end
			ST_PUT: begin
				mem_we    = out_free && (cmd_q.op == OP_PUT_CHAR);
				mem_waddr = phys_addr(row_q, col_q, top_q);
				mem_wdata = {attr_q, cmd_q.code};
			end
			ST_READ: begin
			end
			default: begin
			end
		endcase
	end

	// Cell store
	always_ff @(posedge clk) begin
		if (mem_we)
			mem_q[mem_waddr] <= mem_wdata;
		if (mem_re)
			rd_data_q <= mem_q[mem_raddr];
	end

	// Sequencer, cursor and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			attr_q      <= ATTR_RESET;
			col_q       <= '0;
			row_q       <= '0;
			top_q       <= '0;
			clr_addr_q  <= '0;
			clr_end_q   <= ADDR_W'(CELLS - 1);
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we)
				attr_q <= cfg_wdata;
			// a new result loads, otherwise a taken one clears
			if (out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == clr_end_q)
						state_q <= ST_IDLE;
				end
				ST_SCROLL: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == clr_end_q)
						state_q <= ST_PUT;
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						if (cmd.op == OP_READ || cmd.op == OP_READ_ZERO) begin
							state_q <= ST_READ;
						end else begin
							col_q <= col_w;
							if (scroll) begin
								// old top row becomes the blank bottom row
								row_q      <= ROW_LIMIT - 1'b1;
								clr_addr_q <= ADDR_W'(top_q * COLUMNS);
								clr_end_q  <= ADDR_W'(top_q * COLUMNS + COLUMNS - 1);
								top_q      <= top_next;
								state_q    <= ST_SCROLL;
							end else begin
								row_q   <= row_w;
								state_q <= ST_PUT;
							end
						end
					end
				end
				ST_PUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (cmd_q.op == OP_NEWLINE) begin
							col_q <= '0;
							row_q <= row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
					end
				end
				ST_READ: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command latch and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			cmd_q     <= cmd;
			rd_zero_q <= (cmd.op == OP_READ_ZERO);
		end
		if (state_q == ST_PUT && out_free) begin
			cell_q <= '0;
			if (cmd_q.op == OP_NEWLINE) begin
				ocol_q <= '0;
				orow_q <= row_q + 1'b1;
			end else begin
				ocol_q <= col_q + 1'b1;
				orow_q <= row_q;
			end
		end
		if (state_q == ST_READ && out_free) begin
			cell_q <= rd_zero_q ? '0 : rd_data_q;
			ocol_q <= col_q;
			orow_q <= row_q;
		end
	end

endmodule

/* rtl/text_console_cursor_scroll.sv */
`timescale 1ns / 1ps

// Text console with an 80 x 25 store of 16-bit cells (attribute byte over character byte)
// and a cursor with deferred wrap and scroll. A front end classifies each input transfer
// into a two-entry command queue; the back end carries commands out against a single-port
// store with registered read. A put that scrolls goes through a scroll state first:
// scrolling rotates a top-row pointer and then blanks one row, one cell a cycle. After
// reset the store is cleared one cell a cycle, during which input transfers are stalled;
// writes to the attribute register are taken at any time. The result register lets the
// next command start while a result waits to be taken.

module text_console_cursor_scroll import tccs_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              kind,
	input  logic [7:0]        char_code,
	input  logic [ROW_W-1:0]  read_row,
	input  logic [COL_W-1:0]  read_col,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [CELL_W-1:0] cell_value,
	output logic [COL_W-1:0]  cursor_col,
	output logic [ROW_W-1:0]  cursor_row
);

	logic busy;
	logic cmd_valid;
	logic cmd_pop;
	cmd_t cmd;

	// Front end: classify and queue
	tccs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.kind      (kind),
		.char_code (char_code),
		.read_row  (read_row),
		.read_col  (read_col),
		.busy      (busy),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	// Back end: cursor, store and results
	tccs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop),
		.busy       (busy),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cell_value (cell_value),
		.cursor_col (cursor_col),
		.cursor_row (cursor_row)
	);

`ifndef ASSERT_OFF
	a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command popped from empty queue");

	a_no_transfer_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> in_stall)
		else $error("input not stalled during store clear");

	a_cursor_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (cursor_col <= COL_LIMIT && cursor_row <= ROW_LIMIT))
		else $error("cursor beyond limits");

	a_single_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(cursor_col == COL_LIMIT && cursor_row == ROW_LIMIT))
		else $error("wrap and scroll pending together");
`endif

endmodule
